/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain check, sampled on the rising edge, off while in reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/iafp_pkg.sv */
package iafp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'h53;
    localparam logic [3:0] PAYLOAD_LEN = 4'd8;

    // angle: raw * 1800 / 32768 == raw * 225 / 4096
    localparam logic [7:0] ANGLE_MUL   = 8'd225;
    localparam int         ANGLE_SHIFT = 12;

    // temperature: (10 * raw + 3653) / 340, split as (n >> 2) / 85
    localparam logic signed [19:0] TEMP_OFFSET = 20'sd3653;
    localparam logic [17:0]        TEMP_RECIP  = 18'd197380;
    localparam int                 TEMP_SHIFT  = 24;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] roll_raw;
        logic signed [15:0] pitch_raw;
        logic signed [15:0] yaw_raw;
        logic signed [19:0] temp_num;
    } frame_t;

endpackage

/* hw/rtl/imu_angle_frame_parser_top.sv */
// angle frame parser for up to CHANNELS sensor links sharing one byte stream. every word
// is one received byte tagged with its link; each link hunts for 0x55 0x53, collects eight
// payload bytes and checks the summing checksum byte. a good frame gives one output word
// with roll, pitch and yaw in tenths of a degree and temperature in tenths of a degree
// celsius, all truncated toward zero; bad frames and words for links at or above CHANNELS
// are dropped without output. one word is taken every clock cycle while the output keeps
// up; one result can wait at the output without holding the input back, and the input
// stalls only once a second good frame is held behind it. out_valid rises once the
// checksum byte, taken into the input register, has gone through the frame register and
// the output register, the per-link state update and the constant-coefficient multiplies
// each sitting in a stage of their own.
module imu_angle_frame_parser_top #(
    parameter int CHANNELS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         channel,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         frame_channel,
    output logic signed [11:0] roll_tenths,
    output logic signed [11:0] pitch_tenths,
    output logic signed [11:0] yaw_tenths,
    output logic signed [10:0] temp_tenths
);

    logic             in_valid_reg;
    logic [1:0]       channel_reg;
    logic [7:0]       byte_reg;
    logic             parse_ready;
    logic             frame_valid;
    logic             frame_ready;
    iafp_pkg::frame_t frame;

    assign in_ready = !in_valid_reg || parse_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            channel_reg <= channel;
            byte_reg    <= rx_byte;
        end
    end

    iafp_parser #(
        .CHANNELS (CHANNELS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid_reg),
        .in_channel  (channel_reg),
        .in_byte     (byte_reg),
        .ready       (parse_ready),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_ready (frame_ready)
    );

    iafp_convert u_convert (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_valid   (frame_valid),
        .frame         (frame),
        .frame_ready   (frame_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_channel (frame_channel),
        .roll_tenths   (roll_tenths),
        .pitch_tenths  (pitch_tenths),
        .yaw_tenths    (yaw_tenths),
        .temp_tenths   (temp_tenths)
    );

endmodule

/* hw/rtl/iafp_parser.sv */
`include "assert_macros.svh"

module iafp_parser #(
    parameter int CHANNELS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_channel,
    input  logic [7:0]        in_byte,
    output logic              ready,
    output logic              frame_valid,
    output iafp_pkg::frame_t  frame,
    input  logic              frame_ready
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    iafp_pkg::phase_t   phase_reg [CHANNELS];
    logic [3:0]         count_reg [CHANNELS];
    logic [63:0]        store_reg [CHANNELS];

    logic               frame_valid_reg;
    iafp_pkg::frame_t   frame_reg;
    iafp_pkg::frame_t   frame_next;

    logic [CH_W-1:0]    idx;
    logic               in_range;
    logic               take;
    iafp_pkg::phase_t   cur_phase;
    iafp_pkg::phase_t   phase_next;
    logic [3:0]         cur_count;
    logic [3:0]         count_next;
    logic [63:0]        cur_row;
    logic [7:0]         sum;
    logic               store_we;
    logic               frame_good;
    logic signed [19:0] temp_word;

    assign idx      = CH_W'(in_channel);
    assign in_range = int'(in_channel) < CHANNELS;
    assign ready    = !frame_valid_reg || frame_ready;
    assign take     = in_valid && ready && in_range;

    assign cur_phase = phase_reg[idx];
    assign cur_count = count_reg[idx];
    assign cur_row   = store_reg[idx];

    // checksum over both sync bytes and the stored payload
    always_comb
    begin
        sum = iafp_pkg::SYNC_FIRST + iafp_pkg::SYNC_SECOND;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + cur_row[8*i +: 8];
        end
    end

    // next state of the selected channel
    always_comb
    begin
        phase_next = cur_phase;
        count_next = cur_count;
        unique case (cur_phase)
            iafp_pkg::PH_HUNT:
            begin
                phase_next = (in_byte == iafp_pkg::SYNC_FIRST) ? iafp_pkg::PH_SYNC2
                                                               : iafp_pkg::PH_HUNT;
            end
            iafp_pkg::PH_SYNC2:
            begin
                // a repeated 0x55 here does not restart the frame
                phase_next = (in_byte == iafp_pkg::SYNC_SECOND) ? iafp_pkg::PH_FRAME
                                                                : iafp_pkg::PH_HUNT;
            end
            iafp_pkg::PH_FRAME:
            begin
                if (cur_count < iafp_pkg::PAYLOAD_LEN)
                begin
                    count_next = cur_count + 4'd1;
                end
                else
                begin
                    phase_next = iafp_pkg::PH_HUNT;
                    count_next = 4'd0;
                end
            end
            default:
            begin
                phase_next = iafp_pkg::PH_HUNT;
                count_next = 4'd0;
            end
        endcase
    end

    // outputs of the selected channel
    always_comb
    begin
        store_we   = 1'b0;
        frame_good = 1'b0;
        unique case (cur_phase)
            iafp_pkg::PH_FRAME:
            begin
                store_we   = take && (cur_count < iafp_pkg::PAYLOAD_LEN);
                frame_good = take && (cur_count >= iafp_pkg::PAYLOAD_LEN)
                             && (sum == in_byte);
            end
            default:
            begin
                store_we   = 1'b0;
                frame_good = 1'b0;
            end
        endcase
    end

    // numerator of the temperature term, 10 * raw + offset
    assign temp_word = {{4{cur_row[63]}}, cur_row[63:48]};

    always_comb
    begin
        frame_next.channel   = in_channel;
        frame_next.roll_raw  = cur_row[15:0];
        frame_next.pitch_raw = cur_row[31:16];
        frame_next.yaw_raw   = cur_row[47:32];
        frame_next.temp_num  = (temp_word <<< 3) + (temp_word <<< 1) + iafp_pkg::TEMP_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                phase_reg[c] <= iafp_pkg::PH_HUNT;
                count_reg[c] <= 4'd0;
            end
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg[idx] <= phase_next;
                count_reg[idx] <= count_next;
            end
            if (ready)
            begin
                frame_valid_reg <= frame_good;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[idx][8*cur_count[2:0] +: 8] <= in_byte;
        end
        if (frame_good)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    `ASSERT_CLK(a_count_bound, clk, rst_n, (in_valid && in_range) |-> (cur_count <= iafp_pkg::PAYLOAD_LEN), "payload count past frame length")
    `ASSERT_CLK(a_count_phase, clk, rst_n, (in_valid && in_range && cur_count != 4'd0) |-> (cur_phase == iafp_pkg::PH_FRAME), "payload count outside a frame")
    `ASSERT_CLK(a_frame_chan, clk, rst_n, frame_good |=> (frame_valid_reg && frame_reg.channel == $past(in_channel)), "good frame not registered")

endmodule

/* hw/rtl/iafp_convert.sv */
`include "assert_macros.svh"

module iafp_convert (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    input  iafp_pkg::frame_t   frame,
    output logic               frame_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         frame_channel,
    output logic signed [11:0] roll_tenths,
    output logic signed [11:0] pitch_tenths,
    output logic signed [11:0] yaw_tenths,
    output logic signed [10:0] temp_tenths
);

    logic               out_valid_reg;
    logic [1:0]         channel_reg;
    logic signed [11:0] roll_reg;
    logic signed [11:0] pitch_reg;
    logic signed [11:0] yaw_reg;
    logic signed [10:0] temp_reg;
    logic               load;

    logic               temp_neg;
    logic [19:0]        temp_abs;
    logic [16:0]        temp_quarter;
    logic [34:0]        temp_prod;
    logic [10:0]        temp_q;
    logic signed [10:0] temp_next;

    // magnitude times 225 over 4096, sign put back after: truncation toward zero
    function automatic logic signed [11:0] angle_tenths(input logic signed [15:0] raw);
        logic [16:0] mag;
        logic [24:0] prod;
        logic [11:0] q;
        mag  = raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};
        prod = mag * iafp_pkg::ANGLE_MUL;
        q    = prod[iafp_pkg::ANGLE_SHIFT +: 12];
        return raw[15] ? (12'sd0 - $signed(q)) : $signed(q);
    endfunction

    // divide by 340 as a quarter then a reciprocal multiply by 1/85
    assign temp_neg     = frame.temp_num[19];
    assign temp_abs     = temp_neg ? (20'd0 - frame.temp_num) : frame.temp_num;
    assign temp_quarter = temp_abs[18:2];
    assign temp_prod    = temp_quarter * iafp_pkg::TEMP_RECIP;
    assign temp_q       = temp_prod[iafp_pkg::TEMP_SHIFT +: 11];
    assign temp_next    = temp_neg ? (11'sd0 - $signed(temp_q)) : $signed(temp_q);

    assign frame_ready = !out_valid_reg || out_ready;
    assign load        = frame_valid && frame_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (frame_ready)
        begin
            out_valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            channel_reg <= frame.channel;
            roll_reg    <= angle_tenths(frame.roll_raw);
            pitch_reg   <= angle_tenths(frame.pitch_raw);
            yaw_reg     <= angle_tenths(frame.yaw_raw);
            temp_reg    <= temp_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_channel = channel_reg;
    assign roll_tenths   = roll_reg;
    assign pitch_tenths  = pitch_reg;
    assign yaw_tenths    = yaw_reg;
    assign temp_tenths   = temp_reg;

    `ASSERT_CLK(a_load_shown, clk, rst_n, load |=> out_valid_reg, "converted word not presented")
    `ASSERT_CLK(a_roll_range, clk, rst_n, out_valid_reg |-> (roll_reg >= -12'sd1800 && roll_reg <= 12'sd1799 && temp_reg >= -11'sd953 && temp_reg <= 11'sd974), "converted value out of range")

endmodule

/* bench/tb_imu_angle_frame_parser_top.sv */
module tb_imu_angle_frame_parser_top;

    localparam int CHANNELS     = 3;
    localparam int RANDOM_WORDS = 2000;
    localparam int SEQ_MAX      = 16;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [1:0]         frame_channel;
        logic signed [11:0] roll;
        logic signed [11:0] pitch;
        logic signed [11:0] yaw;
        logic signed [10:0] temp;
    } angles_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PATTERN,
        READY_RARELY
    } stall_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         channel = '0;
    logic [7:0]         rx_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         frame_channel;
    logic signed [11:0] roll_tenths;
    logic signed [11:0] pitch_tenths;
    logic signed [11:0] yaw_tenths;
    logic signed [10:0] temp_tenths;

    imu_angle_frame_parser_top #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .channel(channel),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_channel(frame_channel),
        .roll_tenths(roll_tenths),
        .pitch_tenths(pitch_tenths),
        .yaw_tenths(yaw_tenths),
        .temp_tenths(temp_tenths)
    );

    // per-link parse state, mirrored for prediction
    iafp_pkg::phase_t link_phase [CHANNELS];
    logic [3:0]       link_count [CHANNELS];
    logic [7:0]       link_payload [CHANNELS][8];
    angles_t          expected_angles [$];
    int               error_count = 0;

    // pending byte sequences per link, so that links interleave
    logic [7:0] seq_bytes [CHANNELS][SEQ_MAX];
    int         seq_len [CHANNELS];
    int         seq_pos [CHANNELS];

    bit          idle_enable = 1'b0;
    int          burst_left = 0;
    stall_mode_t stall_mode = READY_ALWAYS;
    int          stall_left = 0;
    logic [31:0] stall_pat = '0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("%0t: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic logic signed [11:0] angle_of(input logic [7:0] lo, input logic [7:0] hi);
        int raw;
        raw = $signed({hi, lo});
        return 12'((raw * 1800) / 32768);
    endfunction

    function automatic logic signed [10:0] temp_of(input logic [7:0] lo, input logic [7:0] hi);
        int raw;
        raw = $signed({hi, lo});
        return 11'((10 * raw + 3653) / 340);
    endfunction

    // advances one link by one byte; returns 1 when a good frame completes
    function automatic bit parse_byte(input logic [1:0] ch, input logic [7:0] b,
                                      output angles_t frame);
        logic [7:0] sum;
        int         i;
        frame = '0;
        if (ch >= CHANNELS)
            return 1'b0;
        if (link_phase[ch] == iafp_pkg::PH_HUNT)
        begin
            link_phase[ch] = (b == iafp_pkg::SYNC_FIRST) ? iafp_pkg::PH_SYNC2
                                                          : iafp_pkg::PH_HUNT;
            return 1'b0;
        end
        if (link_phase[ch] == iafp_pkg::PH_SYNC2)
        begin
            link_phase[ch] = (b == iafp_pkg::SYNC_SECOND) ? iafp_pkg::PH_FRAME
                                                           : iafp_pkg::PH_HUNT;
            return 1'b0;
        end
        if (link_phase[ch] != iafp_pkg::PH_FRAME)
        begin
            link_phase[ch] = iafp_pkg::PH_HUNT;
            link_count[ch] = '0;
            return 1'b0;
        end
        if (link_count[ch] < iafp_pkg::PAYLOAD_LEN)
        begin
            link_payload[ch][link_count[ch]] = b;
            link_count[ch] = link_count[ch] + 1'b1;
            return 1'b0;
        end
        // ninth byte is the checksum, good or bad the link goes back to hunting
        sum = iafp_pkg::SYNC_FIRST + iafp_pkg::SYNC_SECOND;
        for (i = 0; i < 8; i++)
            sum = sum + link_payload[ch][i];
        link_phase[ch] = iafp_pkg::PH_HUNT;
        link_count[ch] = '0;
        if (sum != b)
            return 1'b0;
        frame.frame_channel = ch;
        frame.roll  = angle_of(link_payload[ch][0], link_payload[ch][1]);
        frame.pitch = angle_of(link_payload[ch][2], link_payload[ch][3]);
        frame.yaw   = angle_of(link_payload[ch][4], link_payload[ch][5]);
        frame.temp  = temp_of(link_payload[ch][6], link_payload[ch][7]);
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch
        angles_t got;
        angles_t want;
        angles_t predicted;
        int      i;
        if (!rst_n)
        begin
            for (i = 0; i < CHANNELS; i++)
            begin
                link_phase[i] = iafp_pkg::PH_HUNT;
                link_count[i] = '0;
            end
            expected_angles.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {frame_channel, roll_tenths, pitch_tenths, yaw_tenths, temp_tenths};
                if (expected_angles.size() == 0)
                begin
                    report_error($sformatf("unexpected frame on link %0d", frame_channel));
                end
                else
                begin
                    want = expected_angles.pop_front();
                    check_field("frame_channel", got.frame_channel, want.frame_channel);
                    check_field("roll_tenths", got.roll, want.roll);
                    check_field("pitch_tenths", got.pitch, want.pitch);
                    check_field("yaw_tenths", got.yaw, want.yaw);
                    check_field("temp_tenths", got.temp, want.temp);
                end
            end
            if (in_valid && in_ready && parse_byte(channel, rx_byte, predicted))
                expected_angles.push_back(predicted);
        end
    end

    // receiver back-pressure, mode changes every so often
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 128);
            stall_pat  = $urandom;
        end
        stall_left--;
        case (stall_mode)
            READY_ALWAYS:  out_ready <= 1'b1;
            READY_MOSTLY:  out_ready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN: out_ready <= stall_pat[stall_left % 32];
            default:       out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_word(input logic [1:0] ch, input logic [7:0] b);
        int gap;
        if (idle_enable)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        channel  <= ch;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // words hold four little-endian 16-bit values: roll, pitch, yaw, temperature
    function automatic void load_frame(input int ch, input logic [63:0] words, input bit corrupt);
        logic [7:0] sum;
        int         i;
        sum = iafp_pkg::SYNC_FIRST + iafp_pkg::SYNC_SECOND;
        seq_bytes[ch][0] = iafp_pkg::SYNC_FIRST;
        seq_bytes[ch][1] = iafp_pkg::SYNC_SECOND;
        for (i = 0; i < 8; i++)
        begin
            seq_bytes[ch][2 + i] = words[8 * i +: 8];
            sum = sum + words[8 * i +: 8];
        end
        seq_bytes[ch][10] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        seq_len[ch] = 11;
        seq_pos[ch] = 0;
    endfunction

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void build_sequence(input int ch);
        int         kind;
        int         i;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            load_frame(ch, {pick_raw(), pick_raw(), pick_raw(), pick_raw()}, kind >= 70);
        end
        else if (kind < 90)
        begin
            // broken sync or a frame cut short
            seq_bytes[ch][0] = iafp_pkg::SYNC_FIRST;
            case ($urandom_range(0, 2))
                0:
                begin
                    b = 8'($urandom);
                    seq_bytes[ch][1] = (b == iafp_pkg::SYNC_SECOND) ? 8'h54 : b;
                    seq_len[ch] = 2;
                end
                1:
                begin
                    seq_bytes[ch][1] = iafp_pkg::SYNC_FIRST;
                    seq_bytes[ch][2] = iafp_pkg::SYNC_SECOND;
                    seq_len[ch] = 3;
                end
                default:
                begin
                    seq_bytes[ch][1] = iafp_pkg::SYNC_SECOND;
                    seq_len[ch] = 2 + $urandom_range(0, 7);
                    for (i = 2; i < seq_len[ch]; i++)
                        seq_bytes[ch][i] = 8'($urandom);
                end
            endcase
            seq_pos[ch] = 0;
        end
        else
        begin
            seq_len[ch] = $urandom_range(1, 4);
            for (i = 0; i < seq_len[ch]; i++)
                seq_bytes[ch][i] = 8'($urandom);
            seq_pos[ch] = 0;
        end
    endfunction

    task automatic send_sequence(input int ch);
        while (seq_pos[ch] < seq_len[ch])
        begin
            send_word(2'(ch), seq_bytes[ch][seq_pos[ch]]);
            seq_pos[ch]++;
        end
    endtask

    // full-scale roll and pitch, yaw -1, top temperature, with an ignored link word mid frame
    task automatic test_extreme_frame();
        load_frame(0, {16'h7fff, 16'hffff, 16'h7fff, 16'h8000}, 1'b0);
        while (seq_pos[0] < 5)
        begin
            send_word(2'd0, seq_bytes[0][seq_pos[0]]);
            seq_pos[0]++;
        end
        send_word(2'd3, iafp_pkg::SYNC_FIRST);
        send_sequence(0);
    endtask

    // a repeated first sync must not start a frame, so the rest gives no result
    task automatic test_stray_sync();
        send_word(2'd1, iafp_pkg::SYNC_FIRST);
        load_frame(1, {16'h8000, 16'h0001, 16'h1234, 16'h4000}, 1'b0);
        send_sequence(1);
    endtask

    task automatic test_random_traffic();
        int random_words;
        int ch;
        random_words = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if (random_words % 250 == 0)
                idle_enable = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 31) == 0)
            begin
                send_word(2'd3, 8'($urandom));
            end
            else
            begin
                ch = $urandom_range(0, CHANNELS - 1);
                if (seq_pos[ch] >= seq_len[ch])
                    build_sequence(ch);
                send_word(2'(ch), seq_bytes[ch][seq_pos[ch]]);
                seq_pos[ch]++;
                random_words++;
            end
        end
    endtask

    initial
    begin
        int waited;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_frame();
        test_stray_sync();
        test_random_traffic();
        in_valid <= 1'b0;

        waited = 0;
        while (expected_angles.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (expected_angles.size() != 0)
            report_error($sformatf("%0d frames never came out", expected_angles.size()));

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
